FILE: design/wtac_pkg.sv
package wtac_pkg;

    // Size of the wave pattern store in bytes (a power of two from eight to sixty-four).
    localparam int PATTERN_BYTES = 16;
    localparam int PAT_AW        = $clog2(PATTERN_BYTES);

    localparam int REG_COUNT = 5;

    // Channel register indexes.
    localparam logic [2:0] REG_NR0 = 3'd0;
    localparam logic [2:0] REG_NR1 = 3'd1;
    localparam logic [2:0] REG_NR2 = 3'd2;
    localparam logic [2:0] REG_NR3 = 3'd3;
    localparam logic [2:0] REG_NR4 = 3'd4;

    localparam logic [8:0]  LENGTH_FULL = 9'd256;
    localparam logic [6:0]  WINDOW_OPEN = 7'd64;
    localparam logic [11:0] PERIOD_BASE = 12'd2048;
    localparam logic [7:0]  LOCKED_BYTE = 8'hff;

    typedef enum logic [2:0] {
        OP_REG_WR = 3'd0,
        OP_REG_RD = 3'd1,
        OP_RAM_WR = 3'd2,
        OP_RAM_RD = 3'd3,
        OP_PERIOD = 3'd4,
        OP_LENGTH = 3'd5,
        OP_RESET  = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    // Bits that always read back as one, per register.
    function automatic logic [7:0] read_mask(input logic [2:0] sel);
        logic [7:0] m;
        unique case (sel)
            REG_NR0: m = 8'h7f;
            REG_NR1: m = 8'hff;
            REG_NR2: m = 8'h9f;
            REG_NR3: m = 8'hff;
            REG_NR4: m = 8'hbf;
            default: m = 8'hff;
        endcase
        return m;
    endfunction

    // Power-up contents of the pattern store; bytes past sixteen are zero.
    function automatic logic [7:0] init_byte(input logic [PAT_AW-1:0] addr);
        logic [7:0] b;
        unique case (8'(addr))
            8'd0:    b = 8'h84;
            8'd1:    b = 8'h40;
            8'd2:    b = 8'h43;
            8'd3:    b = 8'haa;
            8'd4:    b = 8'h2d;
            8'd5:    b = 8'h78;
            8'd6:    b = 8'h92;
            8'd7:    b = 8'h3c;
            8'd8:    b = 8'h60;
            8'd9:    b = 8'h59;
            8'd10:   b = 8'h59;
            8'd11:   b = 8'hb0;
            8'd12:   b = 8'h34;
            8'd13:   b = 8'hb8;
            8'd14:   b = 8'h2e;
            8'd15:   b = 8'hda;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: design/wtac_if.sv
interface wtac_in_if
    import wtac_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [2:0] reg_select;
    logic [3:0] ram_address;
    logic [7:0] write_data;
    logic       power_off;

    modport source (output valid, operation, reg_select, ram_address, write_data, power_off,
                    input ready);
    modport sink   (input valid, operation, reg_select, ram_address, write_data, power_off,
                    output ready);
endinterface

interface wtac_out_if
    import wtac_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [3:0] sample_code;
    logic       channel_on;

    modport source (output valid, read_data, sample_code, channel_on, input ready);
    modport sink   (input valid, read_data, sample_code, channel_on, output ready);
endinterface

FILE: design/wave_table_audio_channel_unit.sv
// The result of an accepted word is registered and is valid in the cycle after the word is accepted.
// Throughput: one word per cycle; out of reset the input is ready whenever the result
// register is empty or its word is being taken in the same cycle.
// Reset (i_rst_n low at a clock edge, synchronous): channel registers, counters and flags clear,
// the result register empties and the pattern store reads back its power-up table.
module wave_table_audio_channel_unit
    import wtac_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    wtac_in_if.sink         i_in,
    wtac_out_if.source      o_out
);

    // Channel state. All of the work for a word happens in the combinational
    // block below, between the input port and the result register.
    logic [7:0]  r_regs [REG_COUNT];
    logic        r_playing;
    logic [8:0]  r_length;
    logic [12:0] r_timer;
    logic [4:0]  r_pos;
    logic [3:0]  r_nibble;
    logic [1:0]  r_volume;
    logic [6:0]  r_window;

    // Pattern store: the bytes themselves carry no reset. A byte whose valid bit
    // is clear reads as its power-up value, so a reset or a table reload only
    // has to clear the valid bits.
    logic [7:0]             r_ram     [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] r_ram_vld;

    // Result register.
    logic       r_out_valid;
    logic [7:0] r_read_data;
    logic [3:0] r_sample;
    logic       r_chan_on;

    logic        accept;
    t_op         op;
    logic        dac_on;

    logic [7:0]  n_regs [REG_COUNT];
    logic        n_playing;
    logic [8:0]  n_length;
    logic [12:0] n_timer;
    logic [4:0]  n_pos;
    logic [3:0]  n_nibble;
    logic [1:0]  n_volume;
    logic [6:0]  n_window;
    logic        n_ram_we;
    logic        n_vld_clear;
    logic [7:0]  n_read_data;
    logic [3:0]  n_sample;

    logic [PAT_AW-1:0] rd_addr;
    logic [PAT_AW-1:0] wr_addr;
    logic [7:0]        rd_byte;
    logic [4:0]        nib_pos;
    logic [3:0]        nib_val;
    logic [10:0]       period;
    logic [12:0]       reload;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = i_rst_n && (!r_out_valid || o_out.ready);
    assign op          = t_op'(i_in.operation);
    assign wr_addr     = PAT_AW'(i_in.ram_address);

    // Position whose nibble is loaded by this word: zero on a trigger, the
    // next position on a period tick.
    assign nib_pos = (op == OP_PERIOD) ? 5'(r_pos + 5'd1) : 5'd0;

    // One read port on the pattern store. While playing, the CPU side sees
    // the byte under the play position instead of the addressed byte.
    always_comb begin
        priority if (op == OP_RAM_RD && r_playing) begin
            rd_addr = PAT_AW'(r_pos[4:1]);
        end else if (op == OP_RAM_RD) begin
            rd_addr = wr_addr;
        end else begin
            rd_addr = PAT_AW'(nib_pos[4:1]);
        end
    end

    assign rd_byte = r_ram_vld[rd_addr] ? r_ram[rd_addr] : init_byte(rd_addr);
    assign nib_val = nib_pos[0] ? rd_byte[3:0] : rd_byte[7:4];

    // Timer reload. A write to NRx4 that triggers uses the period bits it carries.
    assign period = {(op == OP_REG_WR && i_in.reg_select == REG_NR4) ?
                     i_in.write_data[2:0] : r_regs[REG_NR4][2:0], r_regs[REG_NR3]};
    assign reload = {12'(PERIOD_BASE - {1'b0, period}), 1'b0};

    always_comb begin
        logic [12:0] t_dec;
        logic [8:0]  l_dec;

        for (int k = 0; k < REG_COUNT; k++) begin
            n_regs[k] = r_regs[k];
        end
        n_playing   = r_playing;
        n_length    = r_length;
        n_timer     = r_timer;
        n_pos       = r_pos;
        n_nibble    = r_nibble;
        n_volume    = r_volume;
        n_window    = r_window;
        n_ram_we    = 1'b0;
        n_vld_clear = 1'b0;
        n_read_data = 8'h00;
        t_dec       = (r_timer != 13'd0) ? 13'(r_timer - 13'd1) : r_timer;
        l_dec       = (r_length != 9'd0) ? 9'(r_length - 9'd1) : r_length;

        unique case (op)
            OP_REG_WR: begin
                if (i_in.reg_select <= REG_NR4) begin
                    n_regs[i_in.reg_select] = i_in.write_data;
                    unique case (i_in.reg_select)
                        REG_NR0: begin
                            if (!i_in.write_data[7]) begin
                                n_playing = 1'b0;
                            end
                        end
                        REG_NR1: begin
                            n_length = 9'(LENGTH_FULL - {1'b0, i_in.write_data});
                        end
                        REG_NR2: begin
                            n_volume = i_in.write_data[6:5];
                        end
                        REG_NR4: begin
                            // Trigger: restart from position zero with a fresh timer.
                            if (i_in.write_data[7]) begin
                                n_playing = r_regs[REG_NR0][7];
                                if (r_length == 9'd0) begin
                                    n_length = LENGTH_FULL;
                                end
                                n_timer  = reload;
                                n_pos    = 5'd0;
                                n_nibble = nib_val;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_REG_RD: begin
                n_read_data = (i_in.reg_select <= REG_NR4) ?
                              (r_regs[i_in.reg_select] | read_mask(i_in.reg_select)) :
                              LOCKED_BYTE;
            end
            OP_RAM_WR: begin
                // While playing, the store is only open just after a fetch.
                n_ram_we = !r_playing || (r_window != 7'd0);
            end
            OP_RAM_RD: begin
                n_read_data = (!r_playing || r_window != 7'd0) ? rd_byte : LOCKED_BYTE;
            end
            OP_PERIOD: begin
                if (r_playing) begin
                    n_timer  = t_dec;
                    n_window = (r_window != 7'd0) ? 7'(r_window - 7'd1) : r_window;
                    if (t_dec == 13'd0) begin
                        n_pos    = nib_pos;
                        n_nibble = nib_val;
                        n_timer  = reload;
                        n_window = WINDOW_OPEN;
                    end
                end
            end
            OP_LENGTH: begin
                if (r_regs[REG_NR4][6]) begin
                    n_length = l_dec;
                    if (l_dec == 9'd0) begin
                        n_playing = 1'b0;
                    end
                end
            end
            OP_RESET: begin
                for (int k = 0; k < REG_COUNT; k++) begin
                    n_regs[k] = 8'h00;
                end
                n_playing   = 1'b0;
                n_length    = 9'd0;
                n_timer     = 13'd0;
                n_pos       = 5'd0;
                n_nibble    = 4'd0;
                n_volume    = 2'd0;
                n_window    = 7'd0;
                n_vld_clear = !i_in.power_off;
            end
            OP_NONE: begin
            end
        endcase
    end

    // Output sample: volume code zero mutes, otherwise shift right by code minus one.
    assign dac_on = n_regs[REG_NR0][7];
    assign n_sample = (n_playing && dac_on && n_volume != 2'd0) ?
                      (n_nibble >> (n_volume - 2'd1)) : 4'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_regs[k] <= 8'h00;
            end
            r_playing   <= 1'b0;
            r_length    <= 9'd0;
            r_timer     <= 13'd0;
            r_pos       <= 5'd0;
            r_nibble    <= 4'd0;
            r_volume    <= 2'd0;
            r_window    <= 7'd0;
            r_ram_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                for (int k = 0; k < REG_COUNT; k++) begin
                    r_regs[k] <= n_regs[k];
                end
                r_playing   <= n_playing;
                r_length    <= n_length;
                r_timer     <= n_timer;
                r_pos       <= n_pos;
                r_nibble    <= n_nibble;
                r_volume    <= n_volume;
                r_window    <= n_window;
                r_out_valid <= 1'b1;
                if (n_vld_clear) begin
                    r_ram_vld <= '0;
                end else if (n_ram_we) begin
                    r_ram_vld[wr_addr] <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pattern store bytes and result payload carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept && n_ram_we) begin
            r_ram[wr_addr] <= i_in.write_data;
        end
        if (accept) begin
            r_read_data <= n_read_data;
            r_sample    <= n_sample;
            r_chan_on   <= n_playing;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_data   = r_read_data;
    assign o_out.sample_code = r_sample;
    assign o_out.channel_on  = r_chan_on;

endmodule

FILE: dv/wave_table_audio_channel_unit_tb.sv
`timescale 1ns / 1ps

module wave_table_audio_channel_unit_tb;
    import wtac_pkg::*;

    localparam int RAND_WORDS  = 1600;
    localparam int CALM_WORDS  = 200;
    localparam int HOLD_AT     = 500;
    localparam int DRAIN_AT    = 1000;
    localparam int HOLD_CYCLES = 48;
    localparam int CYCLE_LIMIT = 200000;

    // A register index past NRx4: writes are dropped and reads return all ones.
    localparam logic [2:0] SEL_UNUSED = 3'd7;

    localparam logic [7:0] RD_MASK [REG_COUNT] = '{8'h7f, 8'hff, 8'h9f, 8'hff, 8'hbf};
    localparam logic [7:0] WAVE_INIT [16] = '{
        8'h84, 8'h40, 8'h43, 8'haa, 8'h2d, 8'h78, 8'h92, 8'h3c,
        8'h60, 8'h59, 8'h59, 8'hb0, 8'h34, 8'hb8, 8'h2e, 8'hda
    };

    typedef struct {
        t_op        op;
        logic [2:0] sel;
        logic [3:0] addr;
        logic [7:0] data;
        logic       keep;
    } t_word;

    typedef struct {
        logic [7:0] rd;
        logic [3:0] smp;
        logic       on;
    } t_chan_out;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] sel;
        logic [3:0] addr;
        logic [7:0] data;
        logic       keep;
        logic       typed;
        logic [7:0] rd;
        logic [3:0] smp;
        logic       on;
    } t_row;

    // Directed opening. Rows with typed set carry their expected word; the rest are
    // checked against the channel model below.
    localparam int DIR_ROWS = 28;
    localparam t_row DIR_TAB [DIR_ROWS] = '{
        //  op         sel         addr  data   keep  typed rd     smp   on
        '{OP_REG_RD, REG_NR0,    4'h0, 8'h00, 1'b0, 1'b1, 8'h7f, 4'h0, 1'b0},
        '{OP_REG_RD, REG_NR4,    4'h0, 8'h00, 1'b0, 1'b1, 8'hbf, 4'h0, 1'b0},
        '{OP_REG_RD, SEL_UNUSED, 4'h0, 8'h00, 1'b0, 1'b1, 8'hff, 4'h0, 1'b0},
        '{OP_RAM_RD, REG_NR0,    4'h0, 8'h00, 1'b0, 1'b1, 8'h84, 4'h0, 1'b0},
        '{OP_RAM_RD, REG_NR0,    4'hf, 8'h00, 1'b0, 1'b1, 8'hda, 4'h0, 1'b0},
        '{OP_RAM_WR, REG_NR0,    4'hf, 8'h00, 1'b0, 1'b1, 8'h00, 4'h0, 1'b0},
        '{OP_RAM_RD, REG_NR0,    4'hf, 8'hff, 1'b0, 1'b1, 8'h00, 4'h0, 1'b0},
        '{OP_REG_WR, SEL_UNUSED, 4'h0, 8'hff, 1'b0, 1'b1, 8'h00, 4'h0, 1'b0},
        '{OP_REG_WR, REG_NR0,    4'h0, 8'h80, 1'b0, 1'b1, 8'h00, 4'h0, 1'b0},
        '{OP_REG_WR, REG_NR2,    4'h0, 8'h20, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_REG_WR, REG_NR3,    4'h0, 8'hff, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_REG_WR, REG_NR1,    4'h0, 8'hff, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_REG_WR, REG_NR4,    4'h0, 8'hc7, 1'b0, 1'b1, 8'h00, 4'h8, 1'b1},
        '{OP_RAM_RD, REG_NR0,    4'h5, 8'h00, 1'b0, 1'b1, 8'hff, 4'h8, 1'b1},
        '{OP_RAM_WR, REG_NR0,    4'h0, 8'h11, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_PERIOD, REG_NR0,    4'h0, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_PERIOD, REG_NR0,    4'h0, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_RAM_RD, REG_NR0,    4'h9, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_RAM_WR, REG_NR0,    4'h3, 8'h5a, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_REG_WR, REG_NR2,    4'h0, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_REG_RD, REG_NR4,    4'h0, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_LENGTH, REG_NR0,    4'h0, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_NONE,   REG_NR0,    4'h0, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_REG_WR, REG_NR0,    4'h0, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_RESET,  REG_NR0,    4'h0, 8'h00, 1'b1, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_RAM_RD, REG_NR0,    4'h3, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_RESET,  REG_NR0,    4'h0, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0},
        '{OP_RAM_RD, REG_NR0,    4'h3, 8'h00, 1'b0, 1'b1, 8'haa, 4'h0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    wtac_in_if  in_if ();
    wtac_out_if out_if ();

    wave_table_audio_channel_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Channel model state.
    logic [7:0]  nr [REG_COUNT];
    logic [7:0]  wave_ram [PATTERN_BYTES];
    logic        playing;
    logic [8:0]  len_left;
    logic [12:0] freq_timer;
    logic [4:0]  pos;
    logic [3:0]  nibble;
    logic [1:0]  vol;
    logic [6:0]  window;

    t_chan_out chan_out_q [$];
    t_word     plan_q [$];
    int        errors = 0;
    int        cycles = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch on %s: got 0x%02h, want 0x%02h", $time, what, got, want);
        errors++;
    endtask

    task automatic load_pattern();
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            wave_ram[i] = (i < 16) ? WAVE_INIT[i] : 8'h00;
        end
    endtask

    task automatic clear_channel();
        for (int i = 0; i < REG_COUNT; i++) begin
            nr[i] = 8'h00;
        end
        playing    = 1'b0;
        len_left   = '0;
        freq_timer = '0;
        pos        = '0;
        nibble     = '0;
        vol        = '0;
        window     = '0;
    endtask

    function automatic logic [12:0] reload_count();
        int period;
        period = int'({nr[REG_NR4][2:0], nr[REG_NR3]});
        return 13'((int'(PERIOD_BASE) - period) * 2);
    endfunction

    function automatic logic [3:0] nibble_at(input logic [4:0] p);
        logic [7:0] b;
        b = wave_ram[int'(p[4:1]) % PATTERN_BYTES];
        return p[0] ? b[3:0] : b[7:4];
    endfunction

    // Applies one word to the channel model and returns the word it should produce.
    task automatic channel_step(input t_word w, output t_chan_out r);
        int a;
        int shift;
        a     = int'(w.addr) % PATTERN_BYTES;
        r.rd  = 8'h00;
        r.smp = 4'h0;
        case (w.op)
            OP_REG_WR: begin
                if (w.sel < REG_COUNT) begin
                    nr[w.sel] = w.data;
                    case (w.sel)
                        REG_NR0: begin
                            if (!w.data[7]) playing = 1'b0;
                        end
                        REG_NR1: len_left = 9'(LENGTH_FULL - w.data);
                        REG_NR2: vol = w.data[6:5];
                        REG_NR4: begin
                            if (w.data[7]) begin
                                playing = nr[REG_NR0][7];
                                if (len_left == 0) len_left = LENGTH_FULL;
                                freq_timer = reload_count();
                                pos        = '0;
                                nibble     = nibble_at(5'd0);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_REG_RD: begin
                r.rd = (w.sel < REG_COUNT) ? (nr[w.sel] | RD_MASK[w.sel]) : LOCKED_BYTE;
            end
            OP_RAM_WR: begin
                if (!playing || window != 0) wave_ram[a] = w.data;
            end
            OP_RAM_RD: begin
                // While playing, the bus only sees the byte under the play position,
                // and only shortly after the position moved.
                if (playing) begin
                    r.rd = (window != 0) ? wave_ram[int'(pos[4:1]) % PATTERN_BYTES]
                                         : LOCKED_BYTE;
                end else begin
                    r.rd = wave_ram[a];
                end
            end
            OP_PERIOD: begin
                if (playing) begin
                    if (freq_timer != 0) freq_timer--;
                    if (window != 0) window--;
                    if (freq_timer == 0) begin
                        pos        = pos + 5'd1;
                        nibble     = nibble_at(pos);
                        freq_timer = reload_count();
                        window     = WINDOW_OPEN;
                    end
                end
            end
            OP_LENGTH: begin
                if (nr[REG_NR4][6]) begin
                    if (len_left != 0) len_left--;
                    if (len_left == 0) playing = 1'b0;
                end
            end
            OP_RESET: begin
                clear_channel();
                if (!w.keep) load_pattern();
            end
            default: ;
        endcase
        if (playing && nr[REG_NR0][7]) begin
            shift = (vol != 0) ? int'(vol) - 1 : 4;
            r.smp = nibble >> shift;
        end
        r.on = playing;
    endtask

    function automatic t_word rand_word();
        t_word w;
        w.op   = t_op'($urandom_range(0, 7));
        w.sel  = 3'($urandom_range(0, 7));
        w.addr = 4'($urandom_range(0, 15));
        w.data = 8'($urandom_range(0, 255));
        w.keep = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Mostly ticks and bus traffic around a playing channel; now and then a full
    // setup ending in a trigger, with short periods favored so the position moves.
    task automatic plan_words();
        t_word w;
        int    pick;
        if ($urandom_range(0, 29) == 0) begin
            w = rand_word();
            w.op = OP_REG_WR;
            w.sel = REG_NR0;
            w.data[7] = ($urandom_range(0, 7) != 0);
            plan_q.push_back(w);
            w = rand_word();
            w.op = OP_REG_WR;
            w.sel = REG_NR1;
            if ($urandom_range(0, 1) == 1) w.data[7:4] = 4'hf;
            plan_q.push_back(w);
            w = rand_word();
            w.op = OP_REG_WR;
            w.sel = REG_NR2;
            plan_q.push_back(w);
            w = rand_word();
            w.op = OP_REG_WR;
            w.sel = REG_NR3;
            if ($urandom_range(0, 7) != 0) w.data[7:6] = 2'b11;
            plan_q.push_back(w);
            w = rand_word();
            w.op = OP_REG_WR;
            w.sel = REG_NR4;
            w.data[7] = 1'b1;
            if ($urandom_range(0, 7) != 0) w.data[2:0] = 3'b111;
            plan_q.push_back(w);
        end else begin
            w = rand_word();
            pick = $urandom_range(0, 99);
            if (pick < 45)      w.op = OP_PERIOD;
            else if (pick < 55) w.op = OP_RAM_RD;
            else if (pick < 63) w.op = OP_RAM_WR;
            else if (pick < 71) w.op = OP_REG_RD;
            else if (pick < 79) w.op = OP_LENGTH;
            else if (pick < 89) w.op = OP_REG_WR;
            else if (pick < 91) w.op = OP_RESET;
            plan_q.push_back(w);
        end
    endtask

    task automatic offer_word(input t_word w, input bit typed, input t_chan_out fixed);
        t_chan_out r;
        in_if.valid       <= 1'b1;
        in_if.operation   <= w.op;
        in_if.reg_select  <= w.sel;
        in_if.ram_address <= w.addr;
        in_if.write_data  <= w.data;
        in_if.power_off   <= w.keep;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        channel_step(w, r);
        if (typed) begin
            chan_out_q.push_back(fixed);
        end else begin
            chan_out_q.push_back(r);
        end
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    initial begin
        t_word     w;
        t_chan_out fixed;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.operation   <= OP_NONE;
        in_if.reg_select  <= REG_NR0;
        in_if.ram_address <= 4'h0;
        in_if.write_data  <= 8'h00;
        in_if.power_off   <= 1'b0;
        clear_channel();
        load_pattern();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            w.op      = t_op'(DIR_TAB[i].op);
            w.sel     = DIR_TAB[i].sel;
            w.addr    = DIR_TAB[i].addr;
            w.data    = DIR_TAB[i].data;
            w.keep    = DIR_TAB[i].keep;
            fixed.rd  = DIR_TAB[i].rd;
            fixed.smp = DIR_TAB[i].smp;
            fixed.on  = DIR_TAB[i].on;
            offer_word(w, DIR_TAB[i].typed, fixed);
            sender_gap();
        end

        for (int n = 0; n < RAND_WORDS; n++) begin
            if (plan_q.size() == 0) plan_words();
            w = plan_q.pop_front();
            calm = (n >= RAND_WORDS - CALM_WORDS);
            if (n == HOLD_AT) hold_req = 1'b1;
            if (n == DRAIN_AT) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
                while (chan_out_q.size() != 0) @(posedge i_clk);
            end
            offer_word(w, 1'b0, fixed);
            sender_gap();
        end

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (chan_out_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (chan_out_q.size() != 0) begin
            report_mismatch("words left outstanding", 8'(chan_out_q.size()), 8'h00);
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Result side: short random stalls, plus one long hold-off that backs the block up.
    initial begin
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_chan_out want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (chan_out_q.size() == 0) begin
                report_mismatch("word with none expected", out_if.read_data, 8'h00);
            end else begin
                want = chan_out_q.pop_front();
                if (out_if.read_data !== want.rd) begin
                    report_mismatch("read_data", out_if.read_data, want.rd);
                end
                if (out_if.sample_code !== want.smp) begin
                    report_mismatch("sample_code", 8'(out_if.sample_code), 8'(want.smp));
                end
                if (out_if.channel_on !== want.on) begin
                    report_mismatch("channel_on", 8'(out_if.channel_on), 8'(want.on));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
